// ----- design/spiral_matrix_reorder_macros.svh -----
// Assertion macros shared by the checker.
`ifndef SPIRAL_MATRIX_REORDER_MACROS_SVH
`define SPIRAL_MATRIX_REORDER_MACROS_SVH

// Check that cons holds in the cycle after ante, outside reset.
`define SMR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("spiral reorder check failed");

// Check that cons holds in the cycle after ante, reset included.
`define SMR_ASSERT_NEXT_ANY(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("spiral reorder check failed");

`endif

// ----- design/smr_pkg.sv -----
`default_nettype none
package smr_pkg;

  localparam int MAX_ROWS    = 8;
  localparam int MAX_COLS    = 8;
  localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

  localparam int DATA_W  = 32;
  localparam int COUNT_W = 4;
  localparam int LOAD_W  = 7;
  localparam int ADDR_W  = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = CFG_IDX_W'(1);

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(8);

  // Walker command and status between the top level and the address walker.
  typedef struct packed {
    logic start;
    logic advance;
  } walk_ctrl_t;

  typedef struct packed {
    logic busy;
    logic last;
  } walk_stat_t;

  // Map a raw count into 1..maxv.
  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
                                                     input logic [COUNT_W-1:0] maxv);
    logic [COUNT_W-1:0] res;
    if (v == '0) begin
      res = COUNT_W'(1);
    end else if (v > maxv) begin
      res = maxv;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- design/spiral_matrix_reorder.sv -----
// Loading: one element per cycle while in_ready is high; the element completing the matrix
// starts the spiral run. Store reads feed a two-entry output queue; results follow one
// per cycle while out_ready is high, paced by the single read port of the element store.
// Loading of the next matrix resumes the cycle after the last store read is issued.
// Reset (rst, synchronous): row_count = col_count = 8, load index 0, output queue empty;
// store contents stay undefined, no clearing pass.
`default_nettype none
module spiral_matrix_reorder (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [31:0]            element,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [31:0]                 spiral_value,
  output logic                               final_flag,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [smr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [smr_pkg::COUNT_W-1:0]   cfg_data
);
  import smr_pkg::*;

  logic [COUNT_W-1:0] row_count, col_count;
  logic [COUNT_W-1:0] rows, cols;
  logic [LOAD_W-1:0]  load_index;
  logic [LOAD_W-1:0]  total;
  logic               in_fire, load_done;

  walk_ctrl_t        wctrl;
  walk_stat_t        wstat;
  logic [ADDR_W-1:0] raddr;
  logic [DATA_W-1:0] rdata;

  logic              pending, pending_final;
  logic [DATA_W-1:0] q_value [2];
  logic              q_final [2];
  logic              wr_ptr, rd_ptr;
  logic [1:0]        fill;
  logic [1:0]        slots;
  logic              pop, issue;

  assign rows  = clamp_count(row_count, COUNT_W'(MAX_ROWS));
  assign cols  = clamp_count(col_count, COUNT_W'(MAX_COLS));
  assign total = LOAD_W'(rows * cols);

  // Hold input while a configuration transaction is offered, so it lands first.
  assign cfg_ready = 1'b1;
  assign in_ready  = !wstat.busy && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign load_done = in_fire && (load_index == total - LOAD_W'(1));

  // Hold configuration; any write to a mapped register restarts loading.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= COUNT_RESET;
      col_count  <= COUNT_RESET;
      load_index <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ROW_COUNT) begin
        row_count  <= cfg_data;
        load_index <= '0;
      end else if (cfg_index == REG_COL_COUNT) begin
        col_count  <= cfg_data;
        load_index <= '0;
      end
    end else if (in_fire) begin
      load_index <= load_done ? '0 : load_index + LOAD_W'(1);
    end
  end

  // Issue a read only when the queue has room for its data.
  assign pop   = out_valid && out_ready;
  assign slots = fill + 2'(pending);
  assign issue = wstat.busy && ((slots < 2'd2) || pop);

  assign wctrl.start   = load_done;
  assign wctrl.advance = issue;

  smr_store u_store (
    .clk   (clk),
    .we    (in_fire),
    .waddr (load_index[ADDR_W-1:0]),
    .wdata (element),
    .re    (issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  smr_walker u_walker (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (wctrl),
    .rows     (rows),
    .cols     (cols),
    .last_pos (ADDR_W'(total - LOAD_W'(1))),
    .stat     (wstat),
    .addr     (raddr)
  );

  // Track the read in flight and its last flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      pending_final <= wstat.last;
    end
  end

  // Push returning read data into the output queue; pop on each output transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (pending) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(pending) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pending) begin
      q_value[wr_ptr] <= rdata;
      q_final[wr_ptr] <= pending_final;
    end
  end

  assign out_valid    = (fill != '0);
  assign spiral_value = q_value[rd_ptr];
  assign final_flag   = q_final[rd_ptr];

endmodule
`default_nettype wire

// ----- design/smr_store.sv -----
`default_nettype none
module smr_store (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [smr_pkg::ADDR_W-1:0] waddr,
  input  wire logic [smr_pkg::DATA_W-1:0] wdata,
  input  wire logic                       re,
  input  wire logic [smr_pkg::ADDR_W-1:0] raddr,
  output logic      [smr_pkg::DATA_W-1:0] rdata
);
  import smr_pkg::*;

  logic [DATA_W-1:0] mem [STORE_DEPTH];

  // Write one entry per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- design/smr_walker.sv -----
`default_nettype none
module smr_walker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire smr_pkg::walk_ctrl_t         ctrl,
  input  wire logic [smr_pkg::COUNT_W-1:0] rows,
  input  wire logic [smr_pkg::COUNT_W-1:0] cols,
  input  wire logic [smr_pkg::ADDR_W-1:0]  last_pos,
  output smr_pkg::walk_stat_t              stat,
  output logic      [smr_pkg::ADDR_W-1:0]  addr
);
  import smr_pkg::*;

  typedef enum logic {W_IDLE, W_RUN} wstate_t;
  typedef enum logic [1:0] {DIR_RIGHT, DIR_DOWN, DIR_LEFT, DIR_UP} dir_t;

  wstate_t            state;
  dir_t               dir;
  logic [ROW_W-1:0]   r, top, bottom;
  logic [COL_W-1:0]   c, left, right;
  logic [ADDR_W-1:0]  remain;
  logic [COUNT_W-1:0] cols_q;
  logic [ADDR_W+COUNT_W:0] addr_full;

  // Row-major address of the current cell.
  assign addr_full   = (ADDR_W+COUNT_W+1)'(r) * (ADDR_W+COUNT_W+1)'(cols_q)
                     + (ADDR_W+COUNT_W+1)'(c);
  assign addr        = addr_full[ADDR_W-1:0];
  assign stat.busy   = (state == W_RUN);
  assign stat.last   = (remain == '0);

  // Walk the spiral: move along the edge, turn and shrink a bound at its end.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
    end else begin
      unique case (state)
        W_IDLE: begin
          if (ctrl.start) begin
            state  <= W_RUN;
            dir    <= DIR_RIGHT;
            r      <= '0;
            c      <= '0;
            top    <= '0;
            left   <= '0;
            bottom <= ROW_W'(rows - COUNT_W'(1));
            right  <= COL_W'(cols - COUNT_W'(1));
            remain <= last_pos;
            cols_q <= cols;
          end
        end
        W_RUN: begin
          if (ctrl.advance) begin
            if (remain == '0) begin
              state <= W_IDLE;
            end else begin
              remain <= remain - ADDR_W'(1);
              unique case (dir)
                DIR_RIGHT: begin
                  if (c < right) begin
                    c <= c + COL_W'(1);
                  end else begin
                    top <= top + ROW_W'(1);
                    r   <= r + ROW_W'(1);
                    dir <= DIR_DOWN;
                  end
                end
                DIR_DOWN: begin
                  if (r < bottom) begin
                    r <= r + ROW_W'(1);
                  end else begin
                    right <= right - COL_W'(1);
                    c     <= c - COL_W'(1);
                    dir   <= DIR_LEFT;
                  end
                end
                DIR_LEFT: begin
                  if (c > left) begin
                    c <= c - COL_W'(1);
                  end else begin
                    bottom <= bottom - ROW_W'(1);
                    r      <= r - ROW_W'(1);
                    dir    <= DIR_UP;
                  end
                end
                DIR_UP: begin
                  if (r > top) begin
                    r <= r - ROW_W'(1);
                  end else begin
                    left <= left + COL_W'(1);
                    c    <= c + COL_W'(1);
                    dir  <= DIR_RIGHT;
                  end
                end
                default: dir <= DIR_RIGHT;
              endcase
            end
          end
        end
        default: state <= W_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- design/smr_checker.sv -----
`default_nettype none
`include "spiral_matrix_reorder_macros.svh"
module smr_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          out_valid,
  input wire logic                          out_ready,
  input wire logic signed [31:0]            spiral_value,
  input wire logic                          final_flag,
  input wire logic                          cfg_ready
);
  import smr_pkg::*;

  // Hold a stalled result.
  `SMR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(spiral_value) && $stable(final_flag))

  // Reset empties the output queue.
  `SMR_ASSERT_NEXT_ANY(a_reset_empty, rst, !out_valid)

  // Configuration writes are never stalled.
  `SMR_ASSERT_NEXT_ANY(a_cfg_open, 1'b1, cfg_ready)

  // No result can appear right after reset, before any read is issued.
  `SMR_ASSERT_NEXT(a_no_early_out, $past(rst) && !out_valid, !out_valid)

endmodule

bind spiral_matrix_reorder smr_checker u_checker (.*);
`default_nettype wire

// ----- bench/tb_spiral_matrix_reorder.sv -----
`timescale 1ns / 1ps

module tb_spiral_matrix_reorder;
  import smr_pkg::*;

  localparam int TOTAL_ITEMS   = 450;
  localparam int SETTLE_CYCLES = 12;
  localparam int IDLE_LIMIT    = 3000;
  localparam int LONG_HOLD     = 300;

  // Indexes past the end of the register map; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_COL_COUNT + 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = REG_COL_COUNT + 2'd2;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_pattern_t;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic signed [DATA_W-1:0]    element;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [DATA_W-1:0]    spiral_value;
  logic                        final_flag;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [COUNT_W-1:0]          cfg_data;

  spiral_matrix_reorder u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .element      (element),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .spiral_value (spiral_value),
    .final_flag   (final_flag),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Track the matrix load and predict the spiral readout
  class spiral_tracker;
    logic [DATA_W-1:0]        cells [STORE_DEPTH];
    int                       load_idx;
    logic [COUNT_W-1:0]       row_reg;
    logic [COUNT_W-1:0]       col_reg;
    logic signed [DATA_W-1:0] due_value [$];
    bit                       due_final [$];
    int                       errors;

    function new();
      load_idx = 0;
      row_reg  = COUNT_RESET;
      col_reg  = COUNT_RESET;
      errors   = 0;
    endfunction

    // Zero counts as one; anything past the maximum saturates
    function int used_count(input logic [COUNT_W-1:0] raw, input int limit);
      if (raw == '0) return 1;
      if (raw > limit) return limit;
      return raw;
    endfunction

    // Any mapped write restarts loading
    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] data);
      case (idx)
        REG_ROW_COUNT: begin
          row_reg  = data;
          load_idx = 0;
        end
        REG_COL_COUNT: begin
          col_reg  = data;
          load_idx = 0;
        end
        default: ;
      endcase
    endfunction

    function void queue_cell(input int r, input int c, input int cols);
      due_value.insert(due_value.size(), cells[r * cols + c]);
      due_final.insert(due_final.size(), 1'b0);
    endfunction

    // Store one element; on the completing element, queue the whole spiral
    function void take_element(input logic signed [DATA_W-1:0] e);
      int rows, cols;
      int top, bot, lft, rgt, i;
      rows = used_count(row_reg, MAX_ROWS);
      cols = used_count(col_reg, MAX_COLS);
      if (load_idx < STORE_DEPTH) cells[load_idx] = e;
      load_idx = (load_idx + 1) % 128;
      if (load_idx < rows * cols) return;
      load_idx = 0;
      top = 0;
      bot = rows;
      lft = 0;
      rgt = cols;
      while (top < bot && lft < rgt) begin
        for (i = lft; i < rgt; i++) queue_cell(top, i, cols);
        top++;
        for (i = top; i < bot; i++) queue_cell(i, rgt - 1, cols);
        rgt--;
        // skip the return pass when only one row or column remains
        if (top < bot) begin
          for (i = rgt - 1; i >= lft; i--) queue_cell(bot - 1, i, cols);
          bot--;
        end
        if (lft < rgt) begin
          for (i = bot - 1; i >= top; i--) queue_cell(i, lft, cols);
          lft++;
        end
      end
      due_final[due_final.size() - 1] = 1'b1;
    endfunction

    function void match_output(input logic signed [DATA_W-1:0] v, input logic f);
      logic signed [DATA_W-1:0] ev;
      bit                       ef;
      if (due_value.size() == 0) begin
        $error("unexpected result: spiral_value=%0d final_flag=%0b", v, f);
        errors++;
        return;
      end
      ev = due_value.pop_front();
      ef = due_final.pop_front();
      if (v !== ev) begin
        $error("spiral_value mismatch: expected %0d, actual %0d", ev, v);
        errors++;
      end
      if (f !== ef) begin
        $error("final_flag mismatch: expected %0b, actual %0b", ef, f);
        errors++;
      end
    endfunction

    function int pending();
      return due_value.size();
    endfunction
  endclass

  spiral_tracker tracker;
  int            sent;
  int            burst_left;
  bit            gaps_on;
  bit            long_hold;
  int            idle_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sample every transaction; results are checked before new loads are noted
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) tracker.match_output(spiral_value, final_flag);
      if (in_valid && in_ready) tracker.take_element(element);
    end
  end

  // Abort when no transaction of any kind completes for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL spiral_matrix_reorder");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: switch between stall patterns, with one long hold on request
  initial begin
    rx_pattern_t pattern;
    int          left_in_pattern;
    out_ready <= 1'b0;
    pattern = RX_OPEN;
    left_in_pattern = 0;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        if (left_in_pattern == 0) begin
          pattern = rx_pattern_t'($urandom_range(0, 3));
          left_in_pattern = $urandom_range(16, 96);
        end
        left_in_pattern--;
        case (pattern)
          RX_OPEN:   out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= ~out_ready;
        endcase
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] pick_element();
    case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one element and hold it until the transaction completes
  task automatic push_element(input logic signed [DATA_W-1:0] v);
    in_valid <= 1'b1;
    element  <= v;
    do @(posedge clk); while (!(in_valid && in_ready));
    sent++;
  endtask

  // When gaps are enabled, insert a random gap at the end of each burst
  task automatic pace();
    if (!gaps_on) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 15);
    in_valid <= 1'b0;
    repeat ($urandom_range(1, 10)) @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Wait until every predicted result has arrived and the block settles
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int rr, cc, rows, cols, mats, phase;
    tracker    = new();
    sent       = 0;
    burst_left = 0;
    gaps_on    = 1'b0;
    long_hold  = 1'b0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    element   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero row count acts as a single row: a 1x1 matrix
    set_register(REG_ROW_COUNT, COUNT_W'(0));
    set_register(REG_COL_COUNT, COUNT_W'(1));
    push_element(32'sh8000_0000);
    drain();

    // Single row is emitted once, left to right
    set_register(REG_ROW_COUNT, COUNT_W'(1));
    set_register(REG_COL_COUNT, COUNT_W'(4));
    push_element(32'sh7FFF_FFFF);
    push_element('0);
    push_element(-1);
    push_element(32'sh5555_5555);
    drain();

    // Single column is emitted once, top to bottom
    set_register(REG_ROW_COUNT, COUNT_W'(3));
    set_register(REG_COL_COUNT, COUNT_W'(1));
    push_element(32'shAAAA_AAAA);
    push_element(1);
    push_element(-2);
    drain();

    set_register(REG_ROW_COUNT, COUNT_W'(2));
    set_register(REG_COL_COUNT, COUNT_W'(3));
    repeat (6) push_element(pick_element());
    drain();

    // Writes to unmapped indexes must not disturb a load in progress
    set_register(REG_ROW_COUNT, COUNT_W'(2));
    set_register(REG_COL_COUNT, COUNT_W'(2));
    push_element(11);
    push_element(-12);
    drain();
    set_register(REG_SPARE_LO, COUNT_W'(0));
    set_register(REG_SPARE_HI, COUNT_W'(15));
    push_element(13);
    push_element(-14);
    drain();

    // A mapped write mid-load restarts the matrix
    push_element(99);
    drain();
    set_register(REG_ROW_COUNT, COUNT_W'(2));
    repeat (4) push_element(pick_element());
    drain();

    // Random phases: new shape, whole matrices, sometimes an abandoned partial one
    phase = 0;
    while (sent < TOTAL_ITEMS) begin
      case (phase)
        0: begin
          rr = 15;
          cc = 8;
        end
        1: begin
          rr = 8;
          cc = 9;
        end
        default: begin
          rr = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
          cc = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
        end
      endcase
      if ($urandom_range(0, 1)) begin
        set_register(REG_ROW_COUNT, COUNT_W'(rr));
        set_register(REG_COL_COUNT, COUNT_W'(cc));
      end else begin
        set_register(REG_COL_COUNT, COUNT_W'(cc));
        set_register(REG_ROW_COUNT, COUNT_W'(rr));
      end
      if ($urandom_range(0, 7) == 0) begin
        set_register(($urandom_range(0, 1) != 0) ? REG_SPARE_HI : REG_SPARE_LO,
                     COUNT_W'($urandom));
      end
      rows = tracker.used_count(COUNT_W'(rr), MAX_ROWS);
      cols = tracker.used_count(COUNT_W'(cc), MAX_COLS);

      // First phase: stall the receiver long enough for the input to back up
      if (phase == 0) begin
        long_hold = 1'b1;
        gaps_on   = 1'b0;
        mats      = 2;
      end else begin
        gaps_on = ($urandom_range(0, 3) != 0);
        mats    = $urandom_range(1, 3);
      end
      // Keep the item count close to the target
      while (mats > 1 && sent + mats * rows * cols > TOTAL_ITEMS) mats--;
      burst_left = $urandom_range(0, 15);

      repeat (mats * rows * cols) begin
        push_element(pick_element());
        pace();
      end
      if (sent < TOTAL_ITEMS && rows * cols > 1 && $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, rows * cols - 1)) begin
          push_element(pick_element());
          pace();
        end
      end
      drain();
      phase++;
    end

    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("PASS spiral_matrix_reorder");
    end else begin
      $display("FAIL spiral_matrix_reorder");
    end
    $finish;
  end

endmodule
